FILE: sv/dba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_pkg
// Shared constants for the dirty bucket LRU allocator: sizes, field widths
// and operation codes.
// ----------------------------------------------------------------------------
package dba_pkg;

	localparam int BUCKET_CNT = 16;
	localparam int IDX_W      = (BUCKET_CNT > 1) ? $clog2(BUCKET_CNT) : 1;

	localparam int OP_W   = 2;
	localparam int DEV_W  = 4;
	localparam int LEN_W  = 16;
	localparam int BKT_W  = 4;
	localparam int DCNT_W = 5;
	localparam int DCNT_MAX = (1 << DCNT_W) - 1;
	localparam int CNT_W  = ($clog2(BUCKET_CNT + 1) > DCNT_W) ?
		$clog2(BUCKET_CNT + 1) : DCNT_W;

	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 40;

	localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
	localparam logic [OP_W-1:0] OP_FLUSH_OLD = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH_NEW = 2'd2;
	localparam logic [OP_W-1:0] OP_COUNT     = 2'd3;

	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] REG_DEV_ATT = 3'd0;

endpackage

FILE: sv/dirty_bucket_lru_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_bucket_lru_allocator
// Recency-ordered buffer bucket bookkeeping with dirty write-back, walked
// one bucket per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// channel   dir  handshake                   beat
// s_axis    in   s_axis_tvalid/tready        one command
// m_axis    out  m_axis_tvalid/tready/tlast  one write-back or one status
// apb       in   psel/penable/pwrite/pready  device_attached register
//
// Steps: an accept, a walk over the recency list (alloc, flush) or over the
// dirty bits (count), an evict when every bucket is dirty and writes are
// enabled, then a fill or a status beat. A flush without write_ready or
// device_attached skips its walk.
// An alloc stops its walk at the first clean bucket from the tail.
// Output stalls hold the walk on a write-back beat and hold fill/status.
// Reset: bucket state is reset at once, recency list to index order, no clearing pass.
// ----------------------------------------------------------------------------
module dirty_bucket_lru_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	// op[1:0], out_device[5:2], in_device[9:6], byte_count[25:10],
	// write_ready[26], read_ready[27]
	input  logic [dba_pkg::S_DATA_W-1:0]     s_axis_tdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// bucket[3:0], ok[4], wb_bucket[8:5], wb_device[12:9],
	// wb_length[28:13], dirty_count[33:29]
	output logic [dba_pkg::M_DATA_W-1:0]     m_axis_tdata,
	// wb_valid[0]
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dba_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int NB    = dba_pkg::BUCKET_CNT;
	localparam int IDX_W = dba_pkg::IDX_W;
	localparam int CNT_W = dba_pkg::CNT_W;
	localparam int DEV_W = dba_pkg::DEV_W;
	localparam int LEN_W = dba_pkg::LEN_W;
	localparam int BKT_W = dba_pkg::BKT_W;
	localparam int DCNT_W = dba_pkg::DCNT_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_EVICT = 3'd2;
	localparam logic [2:0] S_FILL  = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;
	localparam logic [2:0] S_COUNT = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(NB - 1);

	// configuration
	logic dev_att_q;
	logic cfg_wr;

	// bucket state
	logic [IDX_W-1:0] rec_q   [NB];
	logic             dirty_q [NB];
	logic [DEV_W-1:0] outc_q  [NB];
	logic [DEV_W-1:0] inc_q   [NB];
	logic [LEN_W-1:0] len_q   [NB];

	// sequencer
	logic [2:0]                  state_q;
	logic [IDX_W-1:0]            pos_q;
	logic [IDX_W-1:0]            idx_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [dba_pkg::OP_W-1:0]    op_q;
	logic [DEV_W-1:0]            od_q;
	logic [DEV_W-1:0]            id_q;
	logic [LEN_W-1:0]            bytes_q;
	logic                        wr_q;
	logic                        rd_q;
	logic                        st_ok_q;
	logic [DCNT_W-1:0]           st_cnt_q;

	// output register
	logic                        m_valid_q;
	logic [dba_pkg::M_DATA_W-1:0] m_data_q;
	logic                        m_user_q;
	logic                        m_last_q;

	// input fields
	logic [dba_pkg::OP_W-1:0] in_op;
	logic [DEV_W-1:0]         in_od;
	logic [DEV_W-1:0]         in_id;
	logic [LEN_W-1:0]         in_bytes;
	logic                     in_wr;
	logic                     in_rd;
	logic                     in_acc;

	// datapath
	logic [IDX_W-1:0] scan_pos;
	logic [IDX_W-1:0] cur_bkt;
	logic [IDX_W-1:0] sel_bkt;
	logic             dirty_rd;
	logic [DEV_W-1:0] outc_rd;
	logic [LEN_W-1:0] len_rd;
	logic             slot_free;
	logic             wb_hit;
	logic             wb_emit;
	logic             fill_ok;
	logic [CNT_W-1:0] cnt_next;
	logic             pos_end;

	logic                 ld;
	logic [BKT_W-1:0]     ld_bucket;
	logic                 ld_ok;
	logic                 ld_wbv;
	logic [BKT_W-1:0]     ld_wbb;
	logic [DEV_W-1:0]     ld_wbd;
	logic [LEN_W-1:0]     ld_wbl;
	logic [DCNT_W-1:0]    ld_cnt;
	logic                 ld_last;

	assign in_op    = s_axis_tdata[1:0];
	assign in_od    = s_axis_tdata[5:2];
	assign in_id    = s_axis_tdata[9:6];
	assign in_bytes = s_axis_tdata[25:10];
	assign in_wr    = s_axis_tdata[26];
	assign in_rd    = s_axis_tdata[27];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;
	assign slot_free     = !m_valid_q || m_axis_tready;

	// APB register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == dba_pkg::REG_DEV_ATT[2]) ? {31'd0, dev_att_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_att_q <= 1'b1;
		end else if (cfg_wr && paddr[2] == dba_pkg::REG_DEV_ATT[2]) begin
			dev_att_q <= pwdata[0];
		end
	end

	// one shared read select for the dirty, out-device and length arrays
	assign pos_end  = (pos_q == POS_LAST);
	assign scan_pos = (op_q == dba_pkg::OP_FLUSH_NEW) ? pos_q : POS_LAST - pos_q;
	assign cur_bkt  = rec_q[scan_pos];

	always_comb begin
		unique case (state_q) inside
			S_EVICT, S_FILL: sel_bkt = idx_q;
			S_COUNT:         sel_bkt = pos_q;
			default:         sel_bkt = cur_bkt;
		endcase
	end

	assign dirty_rd = dirty_q[sel_bkt];
	assign outc_rd  = outc_q[sel_bkt];
	assign len_rd   = len_q[sel_bkt];
	assign wb_hit   = (outc_rd != '0) && dirty_rd;
	assign wb_emit  = wb_hit && (len_rd != '0);
	assign fill_ok  = dev_att_q && rd_q;
	assign cnt_next = cnt_q + CNT_W'(dirty_rd);

	// result beat selection
	always_comb begin
		ld        = 1'b0;
		ld_bucket = '0;
		ld_ok     = 1'b0;
		ld_wbv    = 1'b0;
		ld_wbb    = '0;
		ld_wbd    = '0;
		ld_wbl    = '0;
		ld_cnt    = '0;
		ld_last   = 1'b0;
		unique case (state_q) inside
			S_EVICT, S_FLUSH: begin
				if (wb_emit && slot_free) begin
					ld     = 1'b1;
					ld_ok  = 1'b1;
					ld_wbv = 1'b1;
					ld_wbb = BKT_W'(sel_bkt);
					ld_wbd = outc_rd;
					ld_wbl = len_rd;
				end
			end
			S_FILL: begin
				ld        = slot_free;
				ld_ok     = fill_ok;
				ld_bucket = fill_ok ? BKT_W'(idx_q) : '0;
				ld_last   = 1'b1;
			end
			S_DONE: begin
				ld      = slot_free;
				ld_ok   = st_ok_q;
				ld_cnt  = st_cnt_q;
				ld_last = 1'b1;
			end
			default: ld = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ld) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			m_data_q <= {6'd0, ld_cnt, ld_wbl, ld_wbd, ld_wbb, ld_ok, ld_bucket};
			m_user_q <= ld_wbv;
			m_last_q <= ld_last;
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= in_op;
			od_q    <= in_od;
			id_q    <= in_id;
			bytes_q <= in_bytes;
			wr_q    <= in_wr;
			rd_q    <= in_rd;
		end
	end

	// sequencer and bucket state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pos_q    <= '0;
			idx_q    <= '0;
			cnt_q    <= '0;
			st_ok_q  <= 1'b0;
			st_cnt_q <= '0;
			for (int i = 0; i < NB; i++) begin
				rec_q[i]   <= IDX_W'(i);
				dirty_q[i] <= 1'b0;
				outc_q[i]  <= '0;
				inc_q[i]   <= '0;
				len_q[i]   <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						pos_q    <= '0;
						cnt_q    <= '0;
						st_cnt_q <= '0;
						st_ok_q  <= 1'b0;
						unique case (in_op)
							dba_pkg::OP_ALLOC: state_q <= S_SCAN;
							dba_pkg::OP_COUNT: state_q <= S_COUNT;
							default: begin
								state_q <= (dev_att_q && in_wr) ? S_FLUSH : S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (!dirty_rd) begin
						idx_q   <= cur_bkt;
						state_q <= S_FILL;
					end else if (pos_end) begin
						if (dev_att_q && wr_q) begin
							idx_q   <= rec_q[NB-1];
							state_q <= S_EVICT;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						pos_q <= pos_q + IDX_W'(1);
					end
				end
				S_EVICT: begin
					if (!wb_emit || slot_free) begin
						if (wb_hit) begin
							dirty_q[idx_q] <= 1'b0;
						end
						for (int i = NB - 1; i > 0; i--) begin
							rec_q[i] <= rec_q[i-1];
						end
						rec_q[0] <= idx_q;
						state_q  <= S_FILL;
					end
				end
				S_FILL: begin
					if (slot_free) begin
						outc_q[idx_q] <= od_q;
						inc_q[idx_q]  <= id_q;
						if (fill_ok) begin
							dirty_q[idx_q] <= 1'b1;
							len_q[idx_q]   <= bytes_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (!wb_emit || slot_free) begin
						if (wb_hit) begin
							dirty_q[cur_bkt] <= 1'b0;
						end
						if (pos_end) begin
							st_ok_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							pos_q <= pos_q + IDX_W'(1);
						end
					end
				end
				S_COUNT: begin
					cnt_q <= cnt_next;
					if (pos_end) begin
						st_ok_q  <= 1'b1;
						st_cnt_q <= (cnt_next > CNT_W'(dba_pkg::DCNT_MAX)) ?
							DCNT_W'(dba_pkg::DCNT_MAX) : cnt_next[DCNT_W-1:0];
						state_q  <= S_DONE;
					end else begin
						pos_q <= pos_q + IDX_W'(1);
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("command accepted while sequencer busy");

	a_evict_tail_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVICT) |-> dirty_rd)
		else $error("evicting a clean bucket");

	a_status_ends_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && ld_last) |=> (state_q == S_IDLE))
		else $error("status beat sent before command ended");

	a_status_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser)
		else $error("status beat flagged as write-back");
`endif

endmodule
